// ----- design/tqh_pkg.sv -----
// tqh_pkg: shared types and constants of the triquadratic hexahedron shape evaluator
// factor formats, product formats and the node label table
// no dependencies
package tqh_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CW        = 16;          // coordinate width
  localparam int EW        = CW + 2;      // extended coordinate for factor math
  localparam int FW        = CW + 2;      // factor width, holds -2u and 3 times 1.0
  localparam int PW        = FW + 1;      // rounded first product
  localparam int QW        = PW + FW;     // full second product
  localparam int NODES     = 27;
  localparam int NODE_W    = 5;
  localparam int SV_W      = 16;          // shape value width
  localparam int DV_W      = 17;          // derivative width

  typedef logic signed [FW-1:0] fac_t;
  typedef logic signed [PW-1:0] prod_t;

  // quadratic factors and derivative factors of one coordinate
  typedef struct packed {
    fac_t [2:0] f;
    fac_t [2:0] df;
  } coord_fac_t;

  typedef struct packed {
    coord_fac_t u;
    coord_fac_t v;
    coord_fac_t w;
  } point_fac_t;

  localparam logic [NODE_W-1:0] NODE_LABEL [NODES] = '{
    5'd0,  5'd16, 5'd4,  5'd8,  5'd22, 5'd12, 5'd1,  5'd17, 5'd5,
    5'd11, 5'd25, 5'd15, 5'd20, 5'd26, 5'd21, 5'd9,  5'd23, 5'd13,
    5'd3,  5'd19, 5'd7,  5'd10, 5'd24, 5'd14, 5'd2,  5'd18, 5'd6
  };

endpackage

// ----- design/tqh_front.sv -----
// tqh_front: input register and per-coordinate factor computation
// pushes one factor set per point into the queue
// depends on tqh_pkg
module tqh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tqh_pkg::CW-1:0] in_coord_u,
  input  logic signed [tqh_pkg::CW-1:0] in_coord_v,
  input  logic signed [tqh_pkg::CW-1:0] in_coord_w,
  input  logic                          q_full,
  output logic                          q_push,
  output tqh_pkg::point_fac_t           q_data
);
  import tqh_pkg::*;

  localparam logic signed [EW-1:0]   ONE_E   = EW'(2 ** FRAC_BITS);
  localparam logic signed [EW-1:0]   HALF_E  = EW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [2*EW-1:0] ONE_SQ  = (2*EW)'(2 ** (2 * FRAC_BITS));
  localparam logic signed [2*EW-1:0] RND_F   = (2*EW)'(2 ** (FRAC_BITS - 1));
  localparam logic signed [2*EW-1:0] RND_F1  = (2*EW)'(2 ** FRAC_BITS);

  logic                  fr_v_r, fr_v_nxt;
  logic signed [CW-1:0]  u_r, v_r, w_r, u_nxt, v_nxt, w_nxt;
  logic                  accept;

  function automatic coord_fac_t calc_fac(input logic signed [CW-1:0] c);
    logic signed [EW-1:0]   ce;
    logic signed [EW-1:0]   cm;
    logic signed [EW-1:0]   cp;
    logic signed [2*EW-1:0] t0;
    logic signed [2*EW-1:0] t1;
    logic signed [2*EW-1:0] t2;
    coord_fac_t             r;
    ce = EW'(c);
    cm = ce - ONE_E;
    cp = ce + ONE_E;
    t0 = cm * ce + RND_F1;
    t1 = cp * ce + RND_F1;
    t2 = ONE_SQ - ce * ce + RND_F;
    // half factor folded into one more shift bit
    r.f[0]  = FW'(t0 >>> (FRAC_BITS + 1));
    r.f[1]  = FW'(t1 >>> (FRAC_BITS + 1));
    r.f[2]  = FW'(t2 >>> FRAC_BITS);
    r.df[0] = FW'(ce - HALF_E);
    r.df[1] = FW'(ce + HALF_E);
    r.df[2] = FW'(-(ce <<< 1));
    return r;
  endfunction

  assign q_push   = fr_v_r && !q_full;
  assign in_stall = fr_v_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fr_v_nxt = fr_v_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    w_nxt    = w_r;
    if (q_push) begin
      fr_v_nxt = 1'b0;
    end
    if (accept) begin
      fr_v_nxt = 1'b1;
      u_nxt    = in_coord_u;
      v_nxt    = in_coord_v;
      w_nxt    = in_coord_w;
    end
  end

  always_comb begin
    q_data.u = calc_fac(u_r);
    q_data.v = calc_fac(v_r);
    q_data.w = calc_fac(w_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
    u_r <= u_nxt;
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

endmodule

// ----- design/tqh_queue.sv -----
// tqh_queue: two-entry queue of factor sets between front and back
// depends on tqh_pkg
module tqh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tqh_pkg::point_fac_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                nempty,
  output tqh_pkg::point_fac_t head
);
  import tqh_pkg::*;

  point_fac_t  ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign nempty = (cnt_r != 2'd0);
  assign head   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/tqh_back.sv -----
// tqh_back: node sequencer, two multiply stages and the result register
// walks the 27 nodes of the queue head, i fastest, then j, then k
// depends on tqh_pkg
module tqh_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_nempty,
  input  tqh_pkg::point_fac_t               q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tqh_pkg::NODE_W-1:0]        out_node,
  output logic signed [tqh_pkg::SV_W-1:0]   out_shape_value,
  output logic signed [tqh_pkg::DV_W-1:0]   out_deriv_u,
  output logic signed [tqh_pkg::DV_W-1:0]   out_deriv_v,
  output logic signed [tqh_pkg::DV_W-1:0]   out_deriv_w,
  output logic                              out_last
);
  import tqh_pkg::*;

  localparam logic signed [2*FW-1:0] RND_P  = (2*FW)'(2 ** (FRAC_BITS - 1));
  localparam logic signed [QW-1:0]   RND_Q  = QW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [QW-1:0]   SV_MAX = QW'(2 ** (SV_W - 1) - 1);
  localparam logic signed [QW-1:0]   SV_MIN = QW'(-(2 ** (SV_W - 1)));
  localparam logic signed [QW-1:0]   DV_MAX = QW'(2 ** (DV_W - 1) - 1);
  localparam logic signed [QW-1:0]   DV_MIN = QW'(-(2 ** (DV_W - 1)));

  typedef struct packed {
    prod_t              ab;
    prod_t              dab;
    prod_t              adb;
    fac_t               c;
    fac_t               dc;
    logic [NODE_W-1:0]  node;
    logic               last;
  } s1_t;

  logic [1:0]         i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [NODE_W-1:0]  cnt_r, cnt_nxt;
  logic               s1_v_r, s1_v_nxt;
  s1_t                s1_r, s1_nxt;
  logic               out_v_r, out_v_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic signed [SV_W-1:0] sv_r, sv_nxt;
  logic signed [DV_W-1:0] du_r, du_nxt, dv_r, dv_nxt, dw_r, dw_nxt;
  logic               last_r, last_nxt;
  logic               out_adv, s1_adv, issue, node_last;

  function automatic prod_t mul_rnd1(input fac_t x, input fac_t y);
    logic signed [2*FW-1:0] t;
    t = x * y + RND_P;
    return PW'(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [QW-1:0] mul_rnd2(input prod_t p, input fac_t z);
    logic signed [QW-1:0] t;
    t = p * z + RND_Q;
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic signed [QW-1:0] clamp(input logic signed [QW-1:0] x,
                                                 input logic signed [QW-1:0] lo,
                                                 input logic signed [QW-1:0] hi);
    logic signed [QW-1:0] r;
    r = x;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // ready chain from the result register back to the sequencer
  assign out_adv   = !out_v_r || !out_stall;
  assign s1_adv    = !s1_v_r || out_adv;
  assign issue     = q_nempty && s1_adv;
  assign node_last = (cnt_r == NODE_W'(NODES - 1));
  assign q_pop     = issue && node_last;

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    cnt_nxt = cnt_r;
    if (issue) begin
      if (node_last) begin
        i_nxt   = 2'd0;
        j_nxt   = 2'd0;
        k_nxt   = 2'd0;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + NODE_W'(1);
        if (i_r == 2'd2) begin
          i_nxt = 2'd0;
          if (j_r == 2'd2) begin
            j_nxt = 2'd0;
            k_nxt = k_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end else begin
          i_nxt = i_r + 2'd1;
        end
      end
    end
  end

  // stage 1: first products of each triple
  always_comb begin
    s1_v_nxt    = s1_adv ? issue : s1_v_r;
    s1_nxt      = s1_r;
    if (issue) begin
      s1_nxt.ab   = mul_rnd1(q_head.u.f[i_r],  q_head.v.f[j_r]);
      s1_nxt.dab  = mul_rnd1(q_head.u.df[i_r], q_head.v.f[j_r]);
      s1_nxt.adb  = mul_rnd1(q_head.u.f[i_r],  q_head.v.df[j_r]);
      s1_nxt.c    = q_head.w.f[k_r];
      s1_nxt.dc   = q_head.w.df[k_r];
      s1_nxt.node = NODE_LABEL[cnt_r];
      s1_nxt.last = node_last;
    end
  end

  // stage 2: second products, rounding and saturation into the result register
  always_comb begin
    out_v_nxt = out_adv ? s1_v_r : out_v_r;
    node_nxt  = node_r;
    sv_nxt    = sv_r;
    du_nxt    = du_r;
    dv_nxt    = dv_r;
    dw_nxt    = dw_r;
    last_nxt  = last_r;
    if (out_adv && s1_v_r) begin
      node_nxt = s1_r.node;
      sv_nxt   = SV_W'(clamp(mul_rnd2(s1_r.ab,  s1_r.c),  SV_MIN, SV_MAX));
      du_nxt   = DV_W'(clamp(mul_rnd2(s1_r.dab, s1_r.c),  DV_MIN, DV_MAX));
      dv_nxt   = DV_W'(clamp(mul_rnd2(s1_r.adb, s1_r.c),  DV_MIN, DV_MAX));
      dw_nxt   = DV_W'(clamp(mul_rnd2(s1_r.ab,  s1_r.dc), DV_MIN, DV_MAX));
      last_nxt = s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= 2'd0;
      j_r     <= 2'd0;
      k_r     <= 2'd0;
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    s1_r   <= s1_nxt;
    node_r <= node_nxt;
    sv_r   <= sv_nxt;
    du_r   <= du_nxt;
    dv_r   <= dv_nxt;
    dw_r   <= dw_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_node        = node_r;
  assign out_shape_value = sv_r;
  assign out_deriv_u     = du_r;
  assign out_deriv_v     = dv_r;
  assign out_deriv_w     = dw_r;
  assign out_last        = last_r;

endmodule

// ----- design/triquadratic_hex_shape_eval_unit.sv -----
// triquadratic_hex_shape_eval_unit: 27-node hexahedron shape functions and derivatives
// top level, joins tqh_front, tqh_queue and tqh_back
// depends on tqh_pkg
//
// Input channel: one beat carries a local point (u, v, w), signed Q2.14, any bit
// pattern. Result channel: 27 beats per point, one per node, i fastest, then j,
// then k, each with the node label minus one, N in Q2.14 and dN/du, dN/dv, dN/dw
// in Q3.14 (rounded half-up, saturated); out_last marks the 27th beat.
// Both channels: a beat moves on a rising edge with valid high and stall low.
// The first result of a point passes the input register, a queue entry, the stage 1
// register and the result register. The shared multiply pipeline issues one node beat
// per cycle while the result side does not stall.
// The front computes the quadratic factors of a point and parks them in a
// two-entry queue, so up to two more points are taken while results drain.
// A stall on the result side holds the result register, backs up the multiply
// stages and, once the queue is full, raises in_stall.
// Reset (synchronous, active low) empties the pipeline and the queue; no
// clearing pass is needed, input is taken in the first cycle after reset.
module triquadratic_hex_shape_eval_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [tqh_pkg::CW-1:0]   in_coord_u,
  input  logic signed [tqh_pkg::CW-1:0]   in_coord_v,
  input  logic signed [tqh_pkg::CW-1:0]   in_coord_w,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tqh_pkg::NODE_W-1:0]      out_node,
  output logic signed [tqh_pkg::SV_W-1:0] out_shape_value,
  output logic signed [tqh_pkg::DV_W-1:0] out_deriv_u,
  output logic signed [tqh_pkg::DV_W-1:0] out_deriv_v,
  output logic signed [tqh_pkg::DV_W-1:0] out_deriv_w,
  output logic                            out_last
);
  import tqh_pkg::*;

  logic       q_push, q_pop, q_full, q_nempty;
  point_fac_t q_wdata, q_head;

  tqh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_coord_u (in_coord_u),
    .in_coord_v (in_coord_v),
    .in_coord_w (in_coord_w),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  tqh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .nempty    (q_nempty),
    .head      (q_head)
  );

  tqh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nempty        (q_nempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node        (out_node),
    .out_shape_value (out_shape_value),
    .out_deriv_u     (out_deriv_u),
    .out_deriv_v     (out_deriv_v),
    .out_deriv_w     (out_deriv_w),
    .out_last        (out_last)
  );

endmodule

// ----- design/tqh_checker.sv -----
// tqh_checker: port-level assertions for the shape evaluator
// bound to triquadratic_hex_shape_eval_unit
// no package dependencies
module tqh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] in_coord_u,
  input logic signed [15:0] in_coord_v,
  input logic signed [15:0] in_coord_w,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_node,
  input logic signed [15:0] out_shape_value,
  input logic signed [16:0] out_deriv_u,
  input logic signed [16:0] out_deriv_v,
  input logic signed [16:0] out_deriv_w,
  input logic               out_last
);

  // reset empties the result side
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result beat holds its node, last flag, shape value and u derivative
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node) && $stable(out_last)
      && $stable(out_shape_value) && $stable(out_deriv_u))
    else $error("stalled result beat changed");

  // the last beat of a point is always the node labeled 7
  a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_node == 5'd6)
    else $error("last beat carries wrong node");

  // after the first node of a point comes the node labeled 17, never a last beat
  a_first_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_node == 5'd0 |=> !out_valid || out_node == 5'd16)
    else $error("node order broken after first node");

endmodule

bind triquadratic_hex_shape_eval_unit tqh_checker u_tqh_checker (.*);
